[sv/pvj_pkg.sv]
// pvj_pkg: shared types, register indexes, command codes and constant tables
// for the pitch vibrato/jitter tick block. No dependencies.
package pvj_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_VIB_DEPTH_MAX  = 3'd0;
    localparam logic [2:0] REG_VIB_DELAY      = 3'd1;
    localparam logic [2:0] REG_VIB_RAMP_STEPS = 3'd2;
    localparam logic [2:0] REG_VIB_RAMP_ADD   = 3'd3;
    localparam logic [2:0] REG_VIB_RATE_ADD   = 3'd4;
    localparam logic [2:0] REG_VIB_TABLE_STEP = 3'd5;
    localparam logic [2:0] REG_RANDOM_RATE    = 3'd6;
    localparam logic [2:0] REG_RANDOM_MASK    = 3'd7;

    localparam logic CMD_NOTE_START = 1'b0;
    localparam logic CMD_TICK       = 1'b1;

    // Pitches at or above one full octave span wrap down
    localparam logic [14:0] PITCH_WRAP = 15'h6000;

    typedef struct packed {
        logic [15:0] vib_depth_max;
        logic [7:0]  vib_delay;
        logic [7:0]  vib_ramp_steps;
        logic [15:0] vib_ramp_add;
        logic [7:0]  vib_rate_add;
        logic [5:0]  vib_table_step;
        logic [7:0]  random_rate;
        logic [15:0] random_mask;
    } t_cfg;

    typedef struct packed {
        logic        command;
        logic [14:0] base_pitch;
    } t_item;

    typedef struct packed {
        logic        emit;
        logic [17:0] pitch;
    } t_res;

    localparam logic [7:0] HALF_WAVE [0:31] = '{
          8'd0,  8'd32,  8'd56,  8'd80, 8'd104, 8'd128, 8'd144, 8'd160,
        8'd176, 8'd192, 8'd208, 8'd224, 8'd232, 8'd240, 8'd240, 8'd248,
        8'd255, 8'd248, 8'd244, 8'd240, 8'd232, 8'd224, 8'd208, 8'd192,
        8'd176, 8'd160, 8'd144, 8'd128, 8'd104,  8'd80,  8'd56,  8'd32
    };

    localparam logic [7:0] JITTER_TAB [0:128] = '{
        8'd159,  8'd60, 8'd178,  8'd82, 8'd175,  8'd69, 8'd199, 8'd137,
         8'd16, 8'd127, 8'd224, 8'd157, 8'd220,  8'd31,  8'd97,  8'd22,
         8'd57, 8'd201, 8'd156, 8'd235,  8'd87,   8'd8, 8'd102, 8'd248,
         8'd90,  8'd36, 8'd191,  8'd14,  8'd62,  8'd21,  8'd75, 8'd219,
        8'd171, 8'd245,  8'd49,  8'd12,  8'd67,   8'd2,  8'd85, 8'd222,
         8'd65, 8'd218, 8'd189, 8'd174,  8'd25, 8'd176,  8'd72,  8'd87,
        8'd186, 8'd163,  8'd54,  8'd11, 8'd249, 8'd223,  8'd23, 8'd168,
          8'd4,  8'd12, 8'd224, 8'd145,  8'd24,  8'd93, 8'd221, 8'd211,
         8'd40, 8'd138, 8'd242,  8'd17,  8'd89, 8'd111,   8'd6,  8'd10,
         8'd52,  8'd42, 8'd121, 8'd172,  8'd94, 8'd167, 8'd131, 8'd198,
         8'd57, 8'd193, 8'd180,  8'd58,  8'd63, 8'd254,  8'd79, 8'd239,
         8'd31,   8'd0,  8'd48, 8'd153,  8'd76,  8'd40, 8'd131, 8'd237,
        8'd138,  8'd47,  8'd44, 8'd102,  8'd63, 8'd214, 8'd108, 8'd183,
         8'd73,  8'd34, 8'd188, 8'd101, 8'd250, 8'd207,   8'd2, 8'd177,
         8'd70, 8'd240, 8'd154, 8'd215, 8'd226,  8'd15,  8'd17, 8'd197,
        8'd116, 8'd246, 8'd122,  8'd44, 8'd143, 8'd251,  8'd25, 8'd106,
        8'd229
    };

endpackage

[sv/pvj_in_if.sv]
// pvj_in_if: input item channel (command, base pitch) with valid/ready.
// Depends on nothing.
interface pvj_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [14:0] base_pitch;

    modport source (output valid, output command, output base_pitch, input ready);
    modport sink   (input valid, input command, input base_pitch, output ready);
endinterface

[sv/pvj_out_if.sv]
// pvj_out_if: result item channel (signed pitch) with valid/ready.
// Depends on nothing.
interface pvj_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] pitch;

    modport source (output valid, output pitch, input ready);
    modport sink   (input valid, input pitch, output ready);
endinterface

[sv/pvj_regs.sv]
// pvj_regs: APB-style configuration register file.
// Depends on pvj_pkg.
module pvj_regs
    import pvj_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_VIB_DEPTH_MAX:  n_cfg.vib_depth_max  = pwdata[15:0];
                REG_VIB_DELAY:      n_cfg.vib_delay      = pwdata[7:0];
                REG_VIB_RAMP_STEPS: n_cfg.vib_ramp_steps = pwdata[7:0];
                REG_VIB_RAMP_ADD:   n_cfg.vib_ramp_add   = pwdata[15:0];
                REG_VIB_RATE_ADD:   n_cfg.vib_rate_add   = pwdata[7:0];
                REG_VIB_TABLE_STEP: n_cfg.vib_table_step = pwdata[5:0];
                REG_RANDOM_RATE:    n_cfg.random_rate    = pwdata[7:0];
                REG_RANDOM_MASK:    n_cfg.random_mask    = pwdata[15:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_VIB_DEPTH_MAX:  prdata = {16'd0, r_cfg.vib_depth_max};
            REG_VIB_DELAY:      prdata = {24'd0, r_cfg.vib_delay};
            REG_VIB_RAMP_STEPS: prdata = {24'd0, r_cfg.vib_ramp_steps};
            REG_VIB_RAMP_ADD:   prdata = {16'd0, r_cfg.vib_ramp_add};
            REG_VIB_RATE_ADD:   prdata = {24'd0, r_cfg.vib_rate_add};
            REG_VIB_TABLE_STEP: prdata = {26'd0, r_cfg.vib_table_step};
            REG_RANDOM_RATE:    prdata = {24'd0, r_cfg.random_rate};
            REG_RANDOM_MASK:    prdata = {16'd0, r_cfg.random_mask};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[sv/pvj_core.sv]
// pvj_core: per-voice modulation state and the single-pass update/result logic.
// Depends on pvj_pkg. Driven one item per i_adv strobe.
module pvj_core
    import pvj_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_adv,
    input  t_item i_item,
    output t_res  o_res
);

    logic [14:0] r_held_pitch,    n_held_pitch;
    logic [7:0]  r_delay_count,   n_delay_count;
    logic [7:0]  r_ramp_count,    n_ramp_count;
    logic [15:0] r_vib_depth_now, n_vib_depth_now;
    logic [7:0]  r_rate_accum,    n_rate_accum;
    logic [5:0]  r_phase_pos,     n_phase_pos;
    logic [8:0]  r_jitter_accum,  n_jitter_accum;
    logic [6:0]  r_jitter_pos,    n_jitter_pos;

    logic        vib_active;
    logic [15:0] depth_new;
    logic [8:0]  rate_sum;
    logic        vib_fire;
    logic [5:0]  phase_new;
    logic [7:0]  tab;
    logic [7:0]  mul_a;
    logic [15:0] prod;
    logic [14:0] amt;
    logic [17:0] vib;
    logic [9:0]  jit_sum;
    logic        jit_step;
    logic [6:0]  jit_pos_new;
    logic [7:0]  jit_idx;
    logic [15:0] jit;
    logic [14:0] note_pitch;

    // Base pitch reduction for out-of-range notes
    assign note_pitch = (i_item.base_pitch >= PITCH_WRAP) ?
                        i_item.base_pitch - PITCH_WRAP : i_item.base_pitch;

    // Vibrato: delay, then ramp, then rate accumulator
    assign vib_active = (i_cfg.vib_depth_max != 16'd0) &&
                        (r_delay_count == i_cfg.vib_delay);

    always_comb begin
        if (r_ramp_count == i_cfg.vib_ramp_steps) begin
            depth_new = i_cfg.vib_depth_max;
        end else if (r_ramp_count != 8'd0) begin
            depth_new = r_vib_depth_now + i_cfg.vib_ramp_add;
        end else begin
            depth_new = i_cfg.vib_ramp_add;
        end
    end

    assign rate_sum  = {1'b0, r_rate_accum} + {1'b0, i_cfg.vib_rate_add};
    assign vib_fire  = vib_active && rate_sum[8];
    assign phase_new = r_phase_pos + i_cfg.vib_table_step;
    assign tab       = HALF_WAVE[phase_new[4:0]];

    // Two depth scalings share one 8x8 multiplier
    assign mul_a = depth_new[15] ? ({1'b0, depth_new[14:8]} + 8'd2)
                                 : {depth_new[14:8], 1'b0};
    assign prod  = mul_a * tab;
    assign amt   = depth_new[15] ? prod[15:1] : {7'd0, prod[15:8]};
    assign vib   = !vib_fire    ? 18'd0 :
                   phase_new[5] ? 18'd0 - {3'd0, amt} : {3'd0, amt};

    // Jitter: accumulator fires only strictly above 256
    assign jit_sum     = {1'b0, r_jitter_accum} + {2'd0, i_cfg.random_rate};
    assign jit_step    = (i_cfg.random_rate != 8'd0) && (jit_sum > 10'd256);
    assign jit_pos_new = r_jitter_pos + 7'd1;
    assign jit_idx     = {1'b0, jit_pos_new};
    assign jit = jit_step ?
                 ({JITTER_TAB[jit_idx + 8'd1], JITTER_TAB[jit_idx]} & i_cfg.random_mask) :
                 16'd0;

    always_comb begin
        n_held_pitch    = r_held_pitch;
        n_delay_count   = r_delay_count;
        n_ramp_count    = r_ramp_count;
        n_vib_depth_now = r_vib_depth_now;
        n_rate_accum    = r_rate_accum;
        n_phase_pos     = r_phase_pos;
        n_jitter_accum  = r_jitter_accum;
        n_jitter_pos    = r_jitter_pos;
        o_res.emit      = 1'b0;
        o_res.pitch     = {3'd0, note_pitch};
        unique case (i_item.command)
            CMD_NOTE_START: begin
                n_held_pitch    = note_pitch;
                n_delay_count   = 8'd0;
                n_ramp_count    = 8'd0;
                n_vib_depth_now = 16'd0;
                n_rate_accum    = 8'd0;
                n_phase_pos     = 6'd0;
                o_res.emit      = 1'b1;
            end
            CMD_TICK: begin
                if (i_cfg.vib_depth_max != 16'd0 && !vib_active) begin
                    n_delay_count = r_delay_count + 8'd1;
                end
                if (vib_active) begin
                    n_vib_depth_now = depth_new;
                    if (r_ramp_count != i_cfg.vib_ramp_steps) begin
                        n_ramp_count = r_ramp_count + 8'd1;
                    end
                    n_rate_accum = rate_sum[7:0];
                end
                if (vib_fire) begin
                    n_phase_pos = phase_new;
                end
                if (i_cfg.random_rate != 8'd0) begin
                    n_jitter_accum = jit_step ? {1'b0, jit_sum[7:0]} : jit_sum[8:0];
                end
                if (jit_step) begin
                    n_jitter_pos = jit_pos_new;
                end
                o_res.emit  = vib_fire || (jit != 16'd0);
                o_res.pitch = {3'd0, r_held_pitch} + vib + {2'd0, jit};
            end
            default: o_res.emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_pitch    <= '0;
            r_delay_count   <= '0;
            r_ramp_count    <= '0;
            r_vib_depth_now <= '0;
            r_rate_accum    <= '0;
            r_phase_pos     <= '0;
            r_jitter_accum  <= '0;
            r_jitter_pos    <= '0;
        end else if (i_adv) begin
            r_held_pitch    <= n_held_pitch;
            r_delay_count   <= n_delay_count;
            r_ramp_count    <= n_ramp_count;
            r_vib_depth_now <= n_vib_depth_now;
            r_rate_accum    <= n_rate_accum;
            r_phase_pos     <= n_phase_pos;
            r_jitter_accum  <= n_jitter_accum;
            r_jitter_pos    <= n_jitter_pos;
        end
    end

    a_jit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jitter_accum <= 9'd256)
        else $error("jitter accumulator above 256");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_delay_count) && $stable(r_jitter_pos) && $stable(r_phase_pos))
        else $error("state moved without an item");

    a_note_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_item.command == CMD_NOTE_START |=>
        r_phase_pos == 6'd0 && r_vib_depth_now == 16'd0 && r_held_pitch < PITCH_WRAP)
        else $error("note start did not clear vibrato state");

endmodule

[sv/pitch_vibrato_jitter_tick.sv]
// pitch_vibrato_jitter_tick: top level - input stage, modulation core, result
// register and APB config. Depends on pvj_pkg, pvj_in_if, pvj_out_if,
// pvj_regs and pvj_core.
//
//  channel | direction | handshake     | payload
//  --------+-----------+---------------+------------------------------------
//  i_in    | in        | valid/ready   | command[0], base_pitch[14:0]
//  o_out   | out       | valid/ready   | pitch[17:0] signed
//  apb     | in        | psel/penable  | paddr[4:0] (4*index), pwdata[31:0]
//
// An item is captured in the input stage, then the core updates the voice
// state and loads the result register in one pass.
// Throughput is one item per cycle while the result register is not stalled;
// the core's 8x8 depth multiply and the final three-way pitch add set the cycle path.
// Reset (i_rst_n low, synchronous) clears config, voice state and both valids.
// A stalled result holds the core's stage; a tick that yields no result still
// waits its turn, and i_in.ready drops only while the input stage is blocked.
module pitch_vibrato_jitter_tick
    import pvj_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    pvj_in_if.sink            i_in,
    pvj_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg        cfg;
    t_res        res;

    // input stage
    logic        r_in_valid;
    t_item       r_item;
    // result register
    logic        r_out_valid;
    logic [17:0] r_out_pitch;

    logic        adv;

    pvj_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Core advances when the result register is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    pvj_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (adv),
        .i_item  (r_item),
        .o_res   (res)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.pitch = r_out_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= res.emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.command    <= i_in.command;
            r_item.base_pitch <= i_in.base_pitch;
        end
        if (adv && res.emit) begin
            r_out_pitch <= res.pitch;
        end
    end

    a_note_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_item.command == CMD_NOTE_START |=> r_out_valid)
        else $error("note start produced no result");

    a_note_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_item.command == CMD_NOTE_START |=> r_out_pitch < 18'h6000)
        else $error("note start pitch out of range");

    a_ready_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && r_out_valid && !o_out.ready)
        else $error("input blocked without a stalled result");

endmodule

[tb/tb_pitch_vibrato_jitter_tick.sv]
// tb_pitch_vibrato_jitter_tick: self-checking bench for the pitch vibrato/jitter block.
// Drives note-start/tick items and APB config writes, and predicts every pitch result.
// Depends on pvj_pkg, pvj_in_if, pvj_out_if and pitch_vibrato_jitter_tick.
module tb_pitch_vibrato_jitter_tick;
    import pvj_pkg::*;

    localparam int STALL_LIMIT = 3000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int DRAIN_PAD   = 16;     // pad past the input and result registers

    // Voice model plus the queue of pitches it expects to see, oldest first.
    class pitch_tracker;
        t_cfg        cfg;
        logic [14:0] held;
        logic [7:0]  dly_cnt;
        logic [7:0]  ramp_cnt;
        logic [15:0] depth_now;
        logic [7:0]  rate_acc;
        logic [5:0]  phase;
        logic [8:0]  jit_acc;
        logic [6:0]  jit_pos;
        logic [17:0] pending_pitch[$];
        int          errors;
        int          emitted;

        function new();
            cfg = '0;
            held = '0;
            dly_cnt = '0;
            ramp_cnt = '0;
            depth_now = '0;
            rate_acc = '0;
            phase = '0;
            jit_acc = '0;
            jit_pos = '0;
            errors = 0;
            emitted = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_VIB_DEPTH_MAX:  cfg.vib_depth_max  = val[15:0];
                REG_VIB_DELAY:      cfg.vib_delay      = val[7:0];
                REG_VIB_RAMP_STEPS: cfg.vib_ramp_steps = val[7:0];
                REG_VIB_RAMP_ADD:   cfg.vib_ramp_add   = val[15:0];
                REG_VIB_RATE_ADD:   cfg.vib_rate_add   = val[7:0];
                REG_VIB_TABLE_STEP: cfg.vib_table_step = val[5:0];
                REG_RANDOM_RATE:    cfg.random_rate    = val[7:0];
                REG_RANDOM_MASK:    cfg.random_mask    = val[15:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic cmd, logic [14:0] bp);
            int vib;
            int jit;
            int tab;
            int amt;
            int sum;
            bit fire;
            vib = 0;
            jit = 0;
            fire = 1'b0;
            if (cmd == CMD_NOTE_START) begin
                // out-of-range pitches fold down by one wrap span
                held = (bp >= PITCH_WRAP) ? bp - PITCH_WRAP : bp;
                dly_cnt = '0;
                ramp_cnt = '0;
                depth_now = '0;
                rate_acc = '0;
                phase = '0;
                pending_pitch.push_back({3'b000, held});
                emitted++;
                return;
            end
            if (cfg.vib_depth_max != 0) begin
                if (dly_cnt != cfg.vib_delay) begin
                    dly_cnt++;
                end else begin
                    if (ramp_cnt == cfg.vib_ramp_steps) begin
                        depth_now = cfg.vib_depth_max;
                    end else begin
                        // first ramp step loads, later ones add (wrapping at 16 bits)
                        depth_now = (ramp_cnt != 0) ? depth_now + cfg.vib_ramp_add
                                                    : cfg.vib_ramp_add;
                        ramp_cnt++;
                    end
                    sum = int'(rate_acc) + int'(cfg.vib_rate_add);
                    rate_acc = sum[7:0];
                    if (sum >= 256) begin
                        phase = phase + cfg.vib_table_step;
                        tab = int'(HALF_WAVE[phase[4:0]]);
                        if (depth_now <= 16'h7FFF)
                            amt = (int'({depth_now[14:8], 1'b0}) * tab) >> 8;
                        else
                            amt = ((int'(depth_now[14:8]) + 2) * tab) >> 1;
                        vib = phase[5] ? -amt : amt;
                        fire = 1'b1;
                    end
                end
            end
            if (cfg.random_rate != 0) begin
                sum = int'(jit_acc) + int'(cfg.random_rate);
                if (sum <= 256) begin
                    jit_acc = sum[8:0];
                end else begin
                    jit_acc = {1'b0, sum[7:0]};
                    jit_pos++;
                    jit = int'({JITTER_TAB[int'(jit_pos) + 1], JITTER_TAB[jit_pos]}
                               & cfg.random_mask);
                end
            end
            if (jit != 0)
                fire = 1'b1;
            if (fire) begin
                sum = int'(held) + vib + jit;
                pending_pitch.push_back(sum[17:0]);
                emitted++;
            end
        endfunction

        function void check_pitch(logic [17:0] got);
            logic [17:0] want;
            if (pending_pitch.size() == 0) begin
                $display("%0t: pitch %0d arrived with nothing expected", $time, $signed(got));
                errors++;
                return;
            end
            want = pending_pitch.pop_front();
            if (got !== want) begin
                $display("%0t: pitch mismatch, expected %0d, got %0d",
                         $time, $signed(want), $signed(got));
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pvj_in_if  in_ch();
    pvj_out_if out_ch();

    pitch_tracker trk;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;   // bumped by stimulus, served by the ready generator

    pitch_vibrato_jitter_tick u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Monitor: everything is sampled on the rising edge, stimulus moves on the
    // falling edge, so sampling never races the drivers.
    always @(posedge i_clk) begin : monitor
        int idle_cycles;
        if (in_ch.valid && in_ch.ready)
            trk.note_item(in_ch.command, in_ch.base_pitch);
        if (out_ch.valid && out_ch.ready)
            trk.check_pitch(out_ch.pitch);
        // watchdog: any handshake (input, result or APB write) counts as progress
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("pitch_vibrato_jitter_tick test failed");
                $finish;
            end
        end
    end

    // Result-side backpressure: random stalls, plus a long hold-off on request
    // so the block fills up and has to push back on its input.
    initial begin : ready_gen
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offer one item; returns at the falling edge after it was taken.
    // Valid stays high across back-to-back items (no drop-and-raise).
    task automatic send_item(input logic cmd, input logic [14:0] bp);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.base_pitch <= bp;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Stop offering, wait until every predicted pitch is back, then idle for pad
    // more cycles so a tick without a result is out of the pipe too.
    task automatic drain(input int pad);
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (trk.pending_pitch.size() != 0) @(negedge i_clk);
        repeat (pad) @(negedge i_clk);
    endtask

    // Setup + access phase, then an idle gap so psel is never re-raised
    // in the step it drops.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        trk.write_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        apb_write(REG_VIB_DEPTH_MAX,  32'(c.vib_depth_max));
        apb_write(REG_VIB_DELAY,      32'(c.vib_delay));
        apb_write(REG_VIB_RAMP_STEPS, 32'(c.vib_ramp_steps));
        apb_write(REG_VIB_RAMP_ADD,   32'(c.vib_ramp_add));
        apb_write(REG_VIB_RATE_ADD,   32'(c.vib_rate_add));
        apb_write(REG_VIB_TABLE_STEP, 32'(c.vib_table_step));
        apb_write(REG_RANDOM_RATE,    32'(c.random_rate));
        apb_write(REG_RANDOM_MASK,    32'(c.random_mask));
    endtask

    // Zero, the top of the range, or a value up to typ (kept small for the
    // counters so vibrato actually kicks in within a note).
    function automatic int pick(int hi, int typ);
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 0;
        if (r == 1)
            return hi;
        return $urandom_range(0, typ);
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.vib_depth_max  = 16'(pick(16'hFFFF, 16'hFFFF));
        c.vib_delay      = 8'(pick(255, 12));
        c.vib_ramp_steps = 8'(pick(255, 12));
        c.vib_ramp_add   = 16'(pick(16'hFFFF, 16'hFFFF));
        c.vib_rate_add   = 8'(pick(255, 255));
        c.vib_table_step = 6'(pick(63, 63));
        c.random_rate    = 8'(pick(255, 255));
        c.random_mask    = 16'(pick(16'hFFFF, 16'hFFFF));
        return c;
    endfunction

    // Mostly whole notes: a note start followed by a run of ticks (now and
    // then long enough to get past a large delay or ramp). The rest is noise.
    // With squeeze set, the receiver is told to hold off early in the phase
    // and later the sender waits for every result before going on.
    task automatic run_phase(input int target, input bit squeeze);
        int  sent;
        int  first_emit;
        int  len;
        bit  held_off;
        bit  paused;
        sent = 0;
        first_emit = trk.emitted;
        held_off = 1'b0;
        paused = 1'b0;
        while (sent < target || trk.emitted - first_emit < 40) begin
            if ($urandom_range(0, 9) < 8) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 280)
                                                  : $urandom_range(4, 40);
                send_item(CMD_NOTE_START, 15'($urandom_range(0, 32767)));
                repeat (len) send_item(CMD_TICK, 15'($urandom_range(0, 32767)));
                sent += len + 1;
            end else begin
                len = $urandom_range(1, 6);
                repeat (len)
                    send_item(1'($urandom_range(0, 1)), 15'($urandom_range(0, 32767)));
                sent += len;
            end
            if (squeeze && !held_off && sent >= 50) begin
                held_off = 1'b1;
                hold_requests++;
            end
            if (squeeze && !paused && sent >= 120) begin
                paused = 1'b1;
                drain(0);
            end
        end
    endtask

    initial begin : stimulus
        t_cfg c;
        int   ph;
        trk = new();
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_NOTE_START;
        in_ch.base_pitch = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_requests = 0;
        tx_idle_pct = 35;
        rx_idle_pct = 73;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Deep depth path, wrapping ramp add, carry nearly every tick, and a
        // jitter rate that lands the accumulator on exactly 256.
        c = '{vib_depth_max: 16'hFFFF, vib_delay: 8'd0, vib_ramp_steps: 8'd2,
              vib_ramp_add: 16'hC000, vib_rate_add: 8'd255, vib_table_step: 6'd33,
              random_rate: 8'd128, random_mask: 16'hFFFF};
        load_config(c);
        send_item(CMD_NOTE_START, 15'h0000);
        send_item(CMD_NOTE_START, 15'h7FFF);    // folds down
        send_item(CMD_NOTE_START, 15'h6000);    // folds to zero
        send_item(CMD_NOTE_START, 15'h5FFF);    // just below the fold
        repeat (8) send_item(CMD_TICK, 15'h7FFF);
        send_item(CMD_NOTE_START, 15'h2AAA);
        repeat (3) send_item(CMD_TICK, 15'h5555);
        drain(DRAIN_PAD);

        // Shallow depth: carries yield zero vibrato but still emit; jitter
        // fires with a zero mask and must not emit on its own; delay counts.
        c = '{vib_depth_max: 16'h00FF, vib_delay: 8'd3, vib_ramp_steps: 8'd0,
              vib_ramp_add: 16'h0000, vib_rate_add: 8'd128, vib_table_step: 6'd32,
              random_rate: 8'd255, random_mask: 16'h0000};
        load_config(c);
        send_item(CMD_NOTE_START, 15'h5555);
        repeat (8) send_item(CMD_TICK, 15'h0000);
        drain(DRAIN_PAD);

        // Each phase overshoots its target by most of one note on average,
        // so six phases land near 1250 items in all.
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                tx_idle_pct = 73;
                rx_idle_pct = 35;
            end else if (ph == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (ph == 0) begin
                c = '{vib_depth_max: 16'hFFFF, vib_delay: 8'd255, vib_ramp_steps: 8'd255,
                      vib_ramp_add: 16'hFFFF, vib_rate_add: 8'd255, vib_table_step: 6'd63,
                      random_rate: 8'd255, random_mask: 16'hFFFF};
            end else begin
                c = random_cfg();
                if (ph == 1)
                    c.random_rate = 8'd0;   // jitter off for a whole phase
            end
            load_config(c);
            run_phase(120, ph == 4);
            drain(DRAIN_PAD);
        end

        if (trk.errors == 0 && trk.pending_pitch.size() == 0)
            $display("pitch_vibrato_jitter_tick test passed");
        else
            $display("pitch_vibrato_jitter_tick test failed");
        $finish;
    end

endmodule
